[design/ubx_frame_deframer_core_macros.svh]
// assertion helpers for the deframer
`ifndef UBX_FRAME_DEFRAMER_CORE_MACROS_SVH
`define UBX_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define UBXFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define UBXFD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define UBXFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UBXFD_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/ubxfd_pkg.sv]
`timescale 1ns / 1ps

package ubxfd_pkg;

    // frame constants
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] ACK_CLASS   = 8'h05;
    localparam logic [7:0] ACK_ACK_ID  = 8'h01;
    localparam logic [7:0] ACK_NAK_ID  = 8'h00;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // ack codes
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NAK  = 2'd2;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  data_byte;
        logic [7:0]  message_class;
        logic [7:0]  message_id;
        logic [15:0] frame_length;
        logic        checksum_good;
        logic [1:0]  ack_kind;
        logic        frame_end;
    } t_result;

endpackage

[design/ubxfd_if.sv]
`timescale 1ns / 1ps

// received byte channel
interface ubxfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface ubxfd_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [7:0]  message_class;
    logic [7:0]  message_id;
    logic [15:0] frame_length;
    logic        checksum_good;
    logic [1:0]  ack_kind;
    logic        frame_end;

    modport source (
        output valid, output item_kind, output data_byte, output message_class,
        output message_id, output frame_length, output checksum_good,
        output ack_kind, output frame_end, input ready
    );
    modport sink (
        input valid, input item_kind, input data_byte, input message_class,
        input message_id, input frame_length, input checksum_good,
        input ack_kind, input frame_end, output ready
    );
endinterface

[design/ubxfd_parser.sv]
`timescale 1ns / 1ps

module ubxfd_parser import ubxfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LENLO   = 4'd4;
    localparam logic [3:0] PH_LENHI   = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CKA     = 4'd7;
    localparam logic [3:0] PH_CKB     = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_ck_a, n_ck_a;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] full_len;
    logic [15:0] seen_inc;

    // running fletcher sums with the current byte folded in
    assign acc_a    = r_sum_a + i_rx_byte;
    assign acc_b    = r_sum_b + acc_a;
    assign full_len = {i_rx_byte, r_len[7:0]};
    assign seen_inc = r_seen + 16'd1;

    // next state and result for the byte on the input
    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_seen  = r_seen;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;

        o_res_valid         = 1'b0;
        o_res.item_kind     = KIND_PAYLOAD;
        o_res.data_byte     = 8'h00;
        o_res.message_class = r_class;
        o_res.message_id    = r_id;
        o_res.frame_length  = r_len;
        o_res.checksum_good = 1'b0;
        o_res.ack_kind      = ACK_NONE;
        o_res.frame_end     = 1'b0;

        case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                end else if (i_rx_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                // sums restart at the class byte
                n_class = i_rx_byte;
                n_sum_a = i_rx_byte;
                n_sum_b = i_rx_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_len   = {8'h00, i_rx_byte};
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_phase = PH_LENHI;
            end
            PH_LENHI: begin
                n_len   = full_len;
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_seen  = 16'd0;
                n_phase = (full_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a         = acc_a;
                n_sum_b         = acc_b;
                n_seen          = seen_inc;
                o_res_valid     = 1'b1;
                o_res.data_byte = i_rx_byte;
                if (seen_inc >= r_len) begin
                    n_phase = PH_CKA;
                end
            end
            PH_CKA: begin
                n_ck_a  = i_rx_byte;
                n_phase = PH_CKB;
            end
            PH_CKB: begin
                o_res_valid         = 1'b1;
                o_res.item_kind     = KIND_STATUS;
                o_res.frame_end     = 1'b1;
                o_res.checksum_good = (r_sum_a == r_ck_a) && (r_sum_b == i_rx_byte);
                if (r_class == ACK_CLASS) begin
                    if (r_id == ACK_ACK_ID) begin
                        o_res.ack_kind = ACK_ACK;
                    end else if (r_id == ACK_NAK_ID) begin
                        o_res.ack_kind = ACK_NAK;
                    end
                end
                n_phase = PH_HUNT1;
            end
            default: begin
                // hunt for the first sync byte
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_class <= 8'h00;
            r_id    <= 8'h00;
            r_len   <= 16'd0;
            r_seen  <= 16'd0;
            r_sum_a <= 8'h00;
            r_sum_b <= 8'h00;
            r_ck_a  <= 8'h00;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
        end
    end

endmodule

[design/ubx_frame_deframer_core.sv]
// ubx frame deframer
// i_rx carries the received serial stream, one byte per item. the block hunts
// for the sync pair, reads class, id and the 16-bit little-endian length, and
// forwards every payload byte as a payload item on o_res. after the two
// checksum bytes it sends one status item with class, id, length, the
// fletcher-8 check result and the ack kind; header, sync and checksum bytes
// give no item.
// output: a result is registered and is on o_res in the cycle after its byte is taken.
// throughput: one byte per cycle unless o_res stalls, set by the single result
// register that sits behind the byte-wide parser state and running sums.
// reset: synchronous, active low; the parser returns to the sync hunt and the
// result register empties.
// stall: while o_res holds an item and o_res.ready is low, i_rx.ready is low;
// the byte that frees the result register may arrive in the same cycle the
// waiting item is taken.
`timescale 1ns / 1ps
`include "ubx_frame_deframer_core_macros.svh"

module ubx_frame_deframer_core import ubxfd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ubxfd_byte_if.sink    i_rx,
    ubxfd_res_if.source   o_res
);

    logic    take;
    logic    res_valid;
    t_result res;
    logic    r_out_valid, n_out_valid;
    t_result r_res;

    // accept when the result register is empty or being drained
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign take       = i_rx.valid && i_rx.ready;

    ubxfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register occupancy
    always_comb begin
        if (take && res_valid) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_res <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.item_kind     = r_res.item_kind;
    assign o_res.data_byte     = r_res.data_byte;
    assign o_res.message_class = r_res.message_class;
    assign o_res.message_id    = r_res.message_id;
    assign o_res.frame_length  = r_res.frame_length;
    assign o_res.checksum_good = r_res.checksum_good;
    assign o_res.ack_kind      = r_res.ack_kind;
    assign o_res.frame_end     = r_res.frame_end;

    // checks
    `UBXFD_ASSERT(a_load_from_take, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(take), "result appeared without a taken byte")
    `UBXFD_ASSERT(a_status_shape, i_clk, i_rst_n,
        (r_out_valid && r_res.item_kind == KIND_STATUS) |->
            (r_res.frame_end && r_res.data_byte == 8'h00), "malformed status item")
    `UBXFD_ASSERT(a_payload_shape, i_clk, i_rst_n,
        (r_out_valid && r_res.item_kind == KIND_PAYLOAD) |->
            (!r_res.frame_end && !r_res.checksum_good && r_res.ack_kind == ACK_NONE),
        "malformed payload item")

endmodule

[dv/ubx_frame_deframer_core_tb.sv]
`timescale 1ns / 1ps

module ubx_frame_deframer_core_tb;
    import ubxfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_500_000;
    localparam int unsigned BYTES_PER_PHASE = 280;
    localparam int unsigned HOLD_AT_BYTE    = 40;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam logic [15:0] LONG_LENGTH     = 16'h0104;

    // parser phases of the deframer
    typedef enum logic [3:0] {
        HUNT_FIRST, HUNT_SECOND, READ_CLASS, READ_ID, READ_LEN_LO,
        READ_LEN_HI, READ_PAYLOAD, READ_CK_A, READ_CK_B
    } t_parse_phase;

    // one byte of the received stream with the idling it is sent under
    typedef struct {
        logic [7:0]  value;
        int unsigned gap_pct;
        int unsigned stall_pct;
    } t_rx_entry;

    logic i_clk;
    logic i_rst_n;

    ubxfd_byte_if rx_if ();
    ubxfd_res_if  res_if ();

    ubx_frame_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    t_rx_entry   rx_stream[$];
    t_result     deframed_items[$];
    int unsigned cur_gap_pct      = 0;
    int unsigned cur_stall_pct    = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned frame_bytes      = 0;
    int unsigned bytes_accepted   = 0;
    int unsigned hold_cycles_left = 0;
    logic        hold_done        = 1'b0;
    int unsigned cycle_count      = 0;
    int unsigned fail_count       = 0;

    // parser state mirrored by the predictor
    t_parse_phase parse_phase   = HUNT_FIRST;
    logic [7:0]   held_class    = '0;
    logic [7:0]   held_id       = '0;
    logic [15:0]  held_length   = '0;
    logic [15:0]  bytes_seen    = '0;
    logic [7:0]   sum_a         = '0;
    logic [7:0]   sum_b         = '0;
    logic [7:0]   received_ck_a = '0;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // fletcher-8 running sums
    function automatic void add_to_sums(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    // advance the parser by one byte and queue the item it yields
    function automatic void parse_rx_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.message_class = held_class;
        case (parse_phase)
            HUNT_SECOND: begin
                if (b == SYNC_SECOND) begin
                    parse_phase = READ_CLASS;
                end else if (b != SYNC_FIRST) begin
                    parse_phase = HUNT_FIRST;
                end
            end
            READ_CLASS: begin
                held_class = b;
                sum_a = '0;
                sum_b = '0;
                add_to_sums(b);
                parse_phase = READ_ID;
            end
            READ_ID: begin
                held_id = b;
                add_to_sums(b);
                parse_phase = READ_LEN_LO;
            end
            READ_LEN_LO: begin
                held_length = {8'h00, b};
                add_to_sums(b);
                parse_phase = READ_LEN_HI;
            end
            READ_LEN_HI: begin
                held_length[15:8] = b;
                add_to_sums(b);
                bytes_seen = '0;
                parse_phase = (held_length == 16'd0) ? READ_CK_A : READ_PAYLOAD;
            end
            READ_PAYLOAD: begin
                add_to_sums(b);
                r.item_kind     = KIND_PAYLOAD;
                r.data_byte     = b;
                r.message_class = held_class;
                r.message_id    = held_id;
                r.frame_length  = held_length;
                r.checksum_good = 1'b0;
                r.ack_kind      = ACK_NONE;
                r.frame_end     = 1'b0;
                deframed_items.insert(deframed_items.size(), r);
                bytes_seen = bytes_seen + 16'd1;
                if (bytes_seen >= held_length) begin
                    parse_phase = READ_CK_A;
                end
            end
            READ_CK_A: begin
                received_ck_a = b;
                parse_phase = READ_CK_B;
            end
            READ_CK_B: begin
                r.item_kind     = KIND_STATUS;
                r.data_byte     = '0;
                r.message_class = held_class;
                r.message_id    = held_id;
                r.frame_length  = held_length;
                r.checksum_good = (sum_a == received_ck_a) && (sum_b == b);
                r.ack_kind      = ACK_NONE;
                if (held_class == ACK_CLASS && held_id == ACK_ACK_ID) begin
                    r.ack_kind = ACK_ACK;
                end else if (held_class == ACK_CLASS && held_id == ACK_NAK_ID) begin
                    r.ack_kind = ACK_NAK;
                end
                r.frame_end = 1'b1;
                deframed_items.insert(deframed_items.size(), r);
                parse_phase = HUNT_FIRST;
            end
            default: begin
                parse_phase = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        t_rx_entry e;
        e.value     = b;
        e.gap_pct   = cur_gap_pct;
        e.stall_pct = cur_stall_pct;
        rx_stream.insert(rx_stream.size(), e);
    endfunction

    // whole frame with sync, header, random payload and checksum
    function automatic void queue_frame(input logic [7:0] cls, input logic [7:0] id,
                                        input logic [15:0] len, input logic corrupt);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] b;
        ck_a = '0;
        ck_b = '0;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        for (int i = 0; i < 4 + int'(len); i++) begin
            case (i)
                0:       b = cls;
                1:       b = id;
                2:       b = len[7:0];
                3:       b = len[15:8];
                default: b = 8'($urandom_range(255, 0));
            endcase
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
            push_byte(b);
        end
        if (corrupt) begin
            if ($urandom_range(1, 0) == 0) begin
                ck_a = ck_a ^ 8'($urandom_range(255, 1));
            end else begin
                ck_b = ck_b ^ 8'($urandom_range(255, 1));
            end
        end
        push_byte(ck_a);
        push_byte(ck_b);
        frame_bytes = frame_bytes + 8 + int'(len);
    endfunction

    // random frame, sometimes after noise or a broken sync pair
    function automatic void queue_random_frame();
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        logic [7:0]  junk;
        if ($urandom_range(4, 0) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                junk = 8'($urandom_range(255, 0));
                // keep noise from forming a sync pair with a runaway length
                if (junk == SYNC_SECOND) begin
                    junk = 8'h00;
                end
                push_byte(junk);
            end
        end
        if ($urandom_range(9, 0) == 0) begin
            junk = 8'($urandom_range(255, 0));
            if (junk == SYNC_FIRST || junk == SYNC_SECOND) begin
                junk = 8'hFF;
            end
            push_byte(SYNC_FIRST);
            push_byte(junk);
        end
        cls = ($urandom_range(3, 0) == 0) ? ACK_CLASS : 8'($urandom_range(255, 0));
        case ($urandom_range(2, 0))
            0:       id = ACK_ACK_ID;
            1:       id = ACK_NAK_ID;
            default: id = 8'($urandom_range(255, 0));
        endcase
        len = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(64, 13))
                                          : 16'($urandom_range(12, 0));
        queue_frame(cls, id, len, $urandom_range(4, 0) == 0);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin : rx_driver
        t_rx_entry next_entry;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                parse_rx_byte(rx_if.rx_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (rx_stream.size() != 0 &&
                        $urandom_range(99, 0) >= rx_stream[0].gap_pct) begin
                    next_entry = rx_stream.pop_front();
                    rx_if.valid    <= 1'b1;
                    rx_if.rx_byte  <= next_entry.value;
                    recv_stall_pct <= next_entry.stall_pct;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles_left <= 0;
        end else if (!hold_done && bytes_accepted >= HOLD_AT_BYTE) begin
            hold_done        <= 1'b1;
            hold_cycles_left <= HOLD_CYCLES;
        end else if (hold_cycles_left != 0) begin
            hold_cycles_left <= hold_cycles_left - 1;
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin : res_monitor
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (deframed_items.size() == 0) begin
                    $error("result item arrived with none expected");
                    fail_count++;
                end else begin
                    want = deframed_items.pop_front();
                    check_field("item_kind", want.item_kind, res_if.item_kind);
                    check_field("data_byte", want.data_byte, res_if.data_byte);
                    check_field("message_class", want.message_class, res_if.message_class);
                    check_field("message_id", want.message_id, res_if.message_id);
                    check_field("frame_length", want.frame_length, res_if.frame_length);
                    check_field("checksum_good", want.checksum_good, res_if.checksum_good);
                    check_field("ack_kind", want.ack_kind, res_if.ack_kind);
                    check_field("frame_end", want.frame_end, res_if.frame_end);
                end
            end
            res_if.ready <= (hold_cycles_left == 0) &&
                            ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ubx_frame_deframer_core_tb NOT OK");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned gap_by_phase[4];
        int unsigned stall_by_phase[4];
        int unsigned total_bytes;
        gap_by_phase   = '{0, 87, 0, 20};
        stall_by_phase = '{0, 0, 87, 20};
        i_rst_n        = 1'b0;

        // repeated first sync, then an empty ack-ack frame
        push_byte(SYNC_FIRST);
        queue_frame(ACK_CLASS, ACK_ACK_ID, 16'd0, 1'b0);
        // broken sync, then an ack-nak frame with a bad checksum
        push_byte(SYNC_FIRST);
        push_byte(8'hFF);
        queue_frame(ACK_CLASS, ACK_NAK_ID, 16'd1, 1'b1);
        // long payload with a nonzero high length byte, run without idling
        queue_frame(8'hFF, 8'hFF, LONG_LENGTH, 1'b0);

        for (int p = 0; p < 4; p++) begin
            cur_gap_pct   = gap_by_phase[p];
            cur_stall_pct = stall_by_phase[p];
            frame_bytes   = 0;
            while (frame_bytes < BYTES_PER_PHASE) begin
                queue_random_frame();
            end
        end
        total_bytes = unsigned'(rx_stream.size());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted < total_bytes) begin
            @(posedge i_clk);
        end
        while (deframed_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && deframed_items.size() == 0) begin
            $display("ubx_frame_deframer_core_tb OK");
        end else begin
            $display("ubx_frame_deframer_core_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ubxfd_pkg.sv
design/ubxfd_if.sv
design/ubxfd_parser.sv
design/ubx_frame_deframer_core.sv
dv/ubx_frame_deframer_core_tb.sv
